[design/mvtc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mvtc_pkg
// Types, codes and helper functions for the mixing valve temperature
// controller: payload structs, controller states and saturation helpers.
// ----------------------------------------------------------------------------
package mvtc_pkg;

  localparam logic        TWO_WAY_MOTOR = 1'b0;
  localparam logic [9:0]  FULL_PTH      = 10'd1000;
  localparam int          PI_SHIFT      = 21;     // 0x200000
  localparam int          DIV_STEPS     = 52;
  localparam int          MUL_STEPS     = 32;
  localparam logic signed [39:0] SAT_MAX = {1'b0, {39{1'b1}}};
  localparam logic signed [39:0] SAT_MIN = {1'b1, 39'd0};

  localparam logic [1:0] ALG_BANG   = 2'd0;
  localparam logic [1:0] ALG_APPROX = 2'd1;
  localparam logic [1:0] ALG_PI     = 2'd2;

  typedef enum logic [1:0] {RQ_NONE, RQ_STOP, RQ_OPEN, RQ_CLOSE} request_t;
  typedef enum logic [2:0] {
    STAT_OK, STAT_DZ, STAT_SENSOR, STAT_DEADBAND, STAT_NOTIMPL
  } status_t;

  typedef enum logic [2:0] {
    CFG_ALGORITHM, CFG_DEADBAND, CFG_DEADZONE, CFG_INTERVAL,
    CFG_STEP, CFG_GAIN, CFG_TI, CFG_SPAN
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] now_time;
    logic [19:0] target_temp;
    logic [19:0] out_temp;
    logic        out_ok;
    logic [19:0] hot_temp;
    logic        hot_ok;
    logic [19:0] cold_temp;
    logic        cold_ok;
    logic        restart;
  } item_t;

  typedef struct packed {
    logic [1:0] request;
    logic [9:0] course_pth;
    logic [2:0] status;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_KP, S_KE, S_Q, S_IT, S_PT, S_FIN
  } ctrl_state_t;

  typedef enum logic [2:0] {AOP_KP, AOP_KE, AOP_Q, AOP_IT, AOP_PT} aop_t;

  typedef struct packed {
    logic load;
    logic commit_dec;
    logic arith_start;
    aop_t arith_op;
    logic cap_sum;
    logic early_out;
    logic fin_out;
  } cmd_t;

  typedef struct packed {
    logic early;
    logic arith_done;
  } sts_t;

  // acceptance check of a move request
  function automatic result_t move_req(input logic neg, input logic [18:0] mag,
                                       input logic [9:0] db);
    logic [9:0] m;
    result_t    r;
    m = (mag >= 19'd1000) ? FULL_PTH : mag[9:0];
    if (TWO_WAY_MOTOR && (mag != 19'd1000)) begin
      r = '{request: RQ_NONE, course_pth: 10'd0, status: STAT_NOTIMPL};
    end else if (!TWO_WAY_MOTOR && (m < db)) begin
      r = '{request: RQ_NONE, course_pth: 10'd0, status: STAT_DEADBAND};
    end else begin
      r = '{request: (neg ? RQ_CLOSE : RQ_OPEN), course_pth: m, status: STAT_OK};
    end
    return r;
  endfunction

  // signed 40-bit value from sign and unsigned magnitude, saturated
  function automatic logic signed [39:0] sat_mag(input logic neg, input logic [83:0] p);
    logic signed [39:0] r;
    if (|p[83:39]) begin
      r = neg ? SAT_MIN : SAT_MAX;
    end else begin
      r = neg ? -signed'(p[39:0]) : signed'(p[39:0]);
    end
    return r;
  endfunction

  function automatic logic signed [39:0] sat_sum(input logic signed [39:0] a,
                                                 input logic signed [39:0] b);
    logic signed [40:0] s;
    logic signed [39:0] r;
    s = {a[39], a} + {b[39], b};
    if (s[40] != s[39]) begin
      r = s[40] ? SAT_MIN : SAT_MAX;
    end else begin
      r = s[39:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[design/mvtc_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mvtc_ctrl
// Sequencer: accepts one item, lets the datapath decide, runs the PI
// divide/multiply chain when needed and loads the result register.
// ----------------------------------------------------------------------------
module mvtc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  output logic               item_ready,
  output logic               result_valid,
  input  wire logic          result_ready,
  input  wire mvtc_pkg::sts_t sts,
  output mvtc_pkg::cmd_t     cmd
);
  import mvtc_pkg::*;

  ctrl_state_t state, state_next;
  logic        out_free;

  assign out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.early_out || cmd.fin_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (item_valid) state_next = S_DECIDE;
      S_DECIDE: begin
        if (!sts.early) state_next = S_KP;
        else if (out_free) state_next = S_IDLE;
      end
      S_KP:     if (sts.arith_done) state_next = S_KE;
      S_KE:     if (sts.arith_done) state_next = S_Q;
      S_Q:      if (sts.arith_done) state_next = S_IT;
      S_IT:     if (sts.arith_done) state_next = S_PT;
      S_PT:     if (sts.arith_done) state_next = S_FIN;
      S_FIN:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        cmd.load   = item_valid;
      end
      S_DECIDE: begin
        if (!sts.early) begin
          cmd.commit_dec  = 1'b1;
          cmd.arith_start = 1'b1;
          cmd.arith_op    = AOP_KP;
        end else if (out_free) begin
          cmd.commit_dec = 1'b1;
          cmd.early_out  = 1'b1;
        end
      end
      S_KP: begin
        cmd.arith_start = sts.arith_done;
        cmd.arith_op    = AOP_KE;
      end
      S_KE: begin
        cmd.arith_start = sts.arith_done;
        cmd.arith_op    = AOP_Q;
      end
      S_Q: begin
        cmd.arith_start = sts.arith_done;
        cmd.arith_op    = AOP_IT;
      end
      S_IT: begin
        cmd.arith_start = sts.arith_done;
        cmd.arith_op    = AOP_PT;
      end
      S_PT:    cmd.cap_sum = sts.arith_done;
      S_FIN:   cmd.fin_out = out_free;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

[design/mvtc_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mvtc_dp
// Datapath: configuration and controller state, early decisions, shared
// restoring divider and shift-add multiplier, PI sum and result register.
// ----------------------------------------------------------------------------
module mvtc_dp (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire mvtc_pkg::cmd_t  cmd,
  output mvtc_pkg::sts_t       sts,
  input  wire mvtc_pkg::item_t item,
  input  wire logic            cfg_valid,
  input  wire logic [2:0]      cfg_index,
  input  wire logic [31:0]     cfg_data,
  output mvtc_pkg::result_t    result
);
  import mvtc_pkg::*;

  // configuration
  logic [1:0]  algorithm;
  logic [9:0]  deadband_pth;
  logic [15:0] temp_deadzone;
  logic [31:0] sample_interval;
  logic [9:0]  approx_step_pth;
  logic [31:0] gain_scaled;
  logic [31:0] integral_time;
  logic [19:0] cold_fallback_span;

  // controller state
  logic [31:0]        last_sample_time;
  logic               loop_armed;
  logic [19:0]        held_out_temp;
  logic signed [39:0] deadband_accum;

  item_t itm;

  // arithmetic unit
  logic        busy, done_q, is_div;
  logic [5:0]  cnt;
  logic [83:0] acc, mcand;
  logic [31:0] mplier, dvs, rem;
  logic [51:0] dq;
  logic [32:0] rem_sh, rem_diff;
  logic        ge;
  logic [31:0] kp, dt_reg;
  logic signed [39:0] iterm, sum;

  // decision signals
  logic signed [22:0] t_tgt, t_out, t_hot, t_prev, half, lo_raw, hi, lo, range_v;
  logic signed [22:0] err, pd;
  logic [19:0]  err_mag, pd_mag;
  logic         err_neg, pd_neg, in_dz, ready_eff, early;
  logic [31:0]  dt_now, last1, dt1, ti;
  logic [41:0]  g42, gk;
  result_t      dec, fin_res;
  logic         d_last_we, d_ready, d_prev_we, d_accum_clr;
  logic [31:0]  d_last;
  logic signed [39:0] s2;
  logic [39:0]  s2_abs;
  logic [18:0]  fmag;

  assign t_tgt  = 23'(itm.target_temp);
  assign t_out  = 23'(itm.out_temp);
  assign t_hot  = 23'(itm.hot_temp);
  assign t_prev = 23'(held_out_temp);
  assign half   = 23'(temp_deadzone[15:1]);
  assign in_dz  = ((t_out - half) < t_tgt) && (t_tgt < (t_out + half));
  assign ready_eff = loop_armed && !itm.restart;

  assign dt_now = itm.now_time - last_sample_time;
  assign last1  = ready_eff ? last_sample_time : itm.now_time;
  assign dt1    = itm.now_time - last1;

  // jacket the outlet reading into the hot/cold range
  assign lo_raw  = itm.cold_ok ? 23'(itm.cold_temp) : t_hot - 23'(cold_fallback_span);
  assign hi      = (t_out > t_hot) ? t_out : t_hot;
  assign lo      = (t_out > t_hot) ? lo_raw : ((t_out < lo_raw) ? t_out : lo_raw);
  assign range_v = hi - lo;

  assign err     = t_tgt - t_out;
  assign err_neg = err[22];
  assign err_mag = err_neg ? 20'(-err) : err[19:0];
  assign pd      = t_prev - t_out;
  assign pd_neg  = pd[22];
  assign pd_mag  = pd_neg ? 20'(-pd) : pd[19:0];

  assign g42 = {10'd0, gain_scaled};
  assign gk  = (g42 << 10) - (g42 << 4) - (g42 << 3);  // times 1000
  assign ti  = (integral_time == 32'd0) ? 32'd1 : integral_time;

  always_comb begin
    early       = 1'b1;
    dec         = '{request: RQ_NONE, course_pth: 10'd0, status: STAT_OK};
    d_last_we   = 1'b0;
    d_last      = itm.now_time;
    d_ready     = ready_eff;
    d_prev_we   = 1'b0;
    d_accum_clr = 1'b0;
    unique case (algorithm)
      ALG_BANG: begin
        if (!itm.out_ok) dec.status = STAT_SENSOR;
        else if (in_dz) dec = '{request: RQ_STOP, course_pth: 10'd0, status: STAT_DZ};
        else dec = move_req(!(t_tgt > t_out), 19'd1000, deadband_pth);
      end
      ALG_APPROX: begin
        d_ready   = 1'b1;
        d_last_we = 1'b1;
        d_last    = last1;
        if (dt1 >= sample_interval) begin
          d_last = itm.now_time;
          if (!itm.out_ok) dec.status = STAT_SENSOR;
          else if (t_out < (t_tgt - half))
            dec = move_req(1'b0, 19'(approx_step_pth), deadband_pth);
          else if (t_out > (t_tgt + half))
            dec = move_req(approx_step_pth != 10'd0, 19'(approx_step_pth), deadband_pth);
          else dec = '{request: RQ_STOP, course_pth: 10'd0, status: STAT_DZ};
        end
      end
      ALG_PI: begin
        if (dt_now >= sample_interval) begin
          d_last_we = 1'b1;
          if (!itm.out_ok) dec.status = STAT_SENSOR;
          else if (in_dz) begin
            d_ready = 1'b0;
            dec = '{request: RQ_STOP, course_pth: 10'd0, status: STAT_DZ};
          end else if (!itm.hot_ok) dec.status = STAT_SENSOR;
          else if (t_tgt <= lo) begin
            d_ready = 1'b0;
            dec = move_req(1'b1, 19'd1000, deadband_pth);
          end else if (t_tgt >= hi) begin
            d_ready = 1'b0;
            dec = move_req(1'b0, 19'd1000, deadband_pth);
          end else if (range_v <= 23'sd1000) begin
            d_ready    = 1'b0;
            dec.status = STAT_DZ;
          end else if (!ready_eff) begin
            // reset cycle: latch outlet, clear accumulator
            d_prev_we   = 1'b1;
            d_accum_clr = 1'b1;
            d_ready     = 1'b1;
          end else begin
            early = 1'b0;
          end
        end
      end
      default: dec.status = STAT_NOTIMPL;
    endcase
  end

  // final PI step: add accumulator, scale down toward zero
  assign s2      = sat_sum(sum, deadband_accum);
  assign s2_abs  = s2[39] ? 40'(-s2) : 40'(s2);
  assign fmag    = s2_abs[39:PI_SHIFT];
  assign fin_res = move_req(s2[39] && (fmag != 19'd0), fmag, deadband_pth);

  assign sts = '{early: early, arith_done: done_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      algorithm          <= ALG_BANG;
      deadband_pth       <= 10'd0;
      temp_deadzone      <= 16'd0;
      sample_interval    <= 32'd1;
      approx_step_pth    <= 10'd0;
      gain_scaled        <= 32'd0;
      integral_time      <= 32'd1;
      cold_fallback_span <= 20'd1;
      last_sample_time   <= 32'd0;
      loop_armed         <= 1'b0;
      held_out_temp      <= 20'd0;
      deadband_accum     <= 40'sd0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_ALGORITHM: algorithm          <= cfg_data[1:0];
          CFG_DEADBAND:  deadband_pth       <= cfg_data[9:0];
          CFG_DEADZONE:  temp_deadzone      <= cfg_data[15:0];
          CFG_INTERVAL:  sample_interval    <= cfg_data;
          CFG_STEP:      approx_step_pth    <= cfg_data[9:0];
          CFG_GAIN:      gain_scaled        <= cfg_data;
          CFG_TI:        integral_time      <= cfg_data;
          CFG_SPAN:      cold_fallback_span <= cfg_data[19:0];
          default:       algorithm          <= algorithm;
        endcase
      end
      if (cmd.commit_dec) begin
        if (d_last_we) last_sample_time <= d_last;
        loop_armed <= d_ready;
        if (d_prev_we) held_out_temp <= itm.out_temp;
        if (d_accum_clr) deadband_accum <= 40'sd0;
      end
      if (cmd.fin_out) begin
        if (fin_res.status != STAT_OK) begin
          deadband_accum <= sat_sum(deadband_accum, iterm);
        end else begin
          held_out_temp  <= itm.out_temp;
          deadband_accum <= 40'sd0;
        end
      end
    end
  end

  // arithmetic unit control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_q <= 1'b0;
      is_div <= 1'b0;
      cnt    <= 6'd0;
    end else begin
      done_q <= 1'b0;
      if (cmd.arith_start) begin
        busy   <= 1'b1;
        cnt    <= 6'd0;
        is_div <= (cmd.arith_op == AOP_KP) || (cmd.arith_op == AOP_Q);
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == (is_div ? 6'(DIV_STEPS - 1) : 6'(MUL_STEPS - 1))) begin
          busy   <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rem_sh   = {rem, dq[51]};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign rem_diff = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (cmd.load) itm <= item;
    if (cmd.commit_dec) dt_reg <= dt_now;
    if (cmd.arith_start) begin
      unique case (cmd.arith_op)
        AOP_KP: begin
          dq  <= {10'd0, gk};
          rem <= 32'd0;
          dvs <= 32'(range_v[21:0]);
        end
        AOP_KE: begin
          kp     <= dq[31:0];
          acc    <= 84'd0;
          mcand  <= {52'd0, dq[31:0]};
          mplier <= 32'(err_mag);
        end
        AOP_Q: begin
          dq  <= acc[51:0];
          rem <= 32'd0;
          dvs <= ti;
        end
        AOP_IT: begin
          acc    <= 84'd0;
          mcand  <= {32'd0, dq};
          mplier <= dt_reg;
        end
        AOP_PT: begin
          iterm  <= sat_mag(err_neg, acc);
          acc    <= 84'd0;
          mcand  <= {52'd0, kp};
          mplier <= 32'(pd_mag);
        end
        default: acc <= 84'd0;
      endcase
    end else if (busy) begin
      if (is_div) begin
        rem <= ge ? rem_diff[31:0] : rem_sh[31:0];
        dq  <= {dq[50:0], ge};
      end else begin
        if (mplier[0]) acc <= acc + mcand;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
      end
    end
    if (cmd.cap_sum) sum <= sat_sum(iterm, sat_mag(pd_neg, acc));
    if (cmd.early_out) result <= dec;
    else if (cmd.fin_out) result <= fin_res;
  end

endmodule
`default_nettype wire

[design/mixing_valve_temp_controller.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mixing_valve_temp_controller
// Mixing valve outlet temperature controller: bang-bang, successive
// approximation and velocity-form PI with deadband accumulation.
// ----------------------------------------------------------------------------
//  channel   signals                              direction
//  item      item_valid / item_ready / item       in
//  result    result_valid / result_ready / result out
//  config    cfg_valid / cfg_ready / cfg_index / cfg_data   in
//
//  one item at a time; a result decided without PI arithmetic is presented
//  from the decide step, and the next item can be accepted after that step
//  a full PI update runs decide, two 52-step divides and three 32-step multiplies
//  on the shared radix-2 unit, then presents its result from the final step
//  a waiting result holds the next item at its decide or final step
//  rst is synchronous and resets state and configuration; config is always ready
// ----------------------------------------------------------------------------
module mixing_valve_temp_controller (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire mvtc_pkg::item_t   item,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output mvtc_pkg::result_t      result,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [31:0]       cfg_data
);
  import mvtc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  mvtc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  mvtc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

endmodule
`default_nettype wire

[design/mvtc_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mvtc_checker
// Port-level checks for the mixing valve temperature controller.
// ----------------------------------------------------------------------------
module mvtc_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              item_valid,
  input wire logic              item_ready,
  input wire logic              result_valid,
  input wire logic              result_ready,
  input wire mvtc_pkg::result_t result
);
  import mvtc_pkg::*;

  // stalled result transaction holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // one item in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item accepted while busy");

  a_course_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.course_pth <= FULL_PTH)
    else $error("course beyond full travel");

  a_no_move_course: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.request == RQ_NONE || result.request == RQ_STOP)
      |-> result.course_pth == 10'd0)
    else $error("course on stop or no request");

endmodule

bind mixing_valve_temp_controller mvtc_checker u_mvtc_checker (.*);
`default_nettype wire
